### design/pnfv_pkg.sv
package pnfv_pkg;

  localparam int unsigned DefHistoryDepth = 256;

  localparam logic signed [11:0] LevelMin = -12'sd1536;
  localparam logic [31:0] StepCapMs       = 32'd200;
  localparam logic [17:0] WindowMinMs     = 18'd2000;
  localparam logic [17:0] WindowPadMs     = 18'd500;
  localparam logic [2:0]  PercentileDiv   = 3'd5;
  // binary search over the 1537 possible levels
  localparam logic [3:0]  SearchPasses    = 4'd11;

  localparam logic signed [11:0] RstAbsThr    = -12'sd640;
  localparam logic [10:0]        RstMargin    = 11'd96;
  localparam logic [15:0]        RstSilence   = 16'd1500;
  localparam logic [15:0]        RstMinRec    = 16'd1000;
  localparam logic [15:0]        RstMinSpeech = 16'd200;

  localparam logic [2:0] RegAbsThr    = 3'd0;
  localparam logic [2:0] RegMargin    = 3'd1;
  localparam logic [2:0] RegSilence   = 3'd2;
  localparam logic [2:0] RegMinRec    = 3'd3;
  localparam logic [2:0] RegMinSpeech = 3'd4;

  typedef struct packed {
    logic               valid;
    logic [31:0]        ts;
    logic signed [11:0] level;
  } entry_t;

  typedef struct packed {
    logic signed [11:0] abs_thr;
    logic [10:0]        margin;
    logic [15:0]        silence;
    logic [15:0]        min_rec;
    logic [15:0]        min_speech;
  } cfg_t;

  typedef enum logic [8:0] {
    StIdle   = 9'b000000001,
    StInsert = 9'b000000010,
    StWindow = 9'b000000100,
    StSearch = 9'b000001000,
    StThresh = 9'b000010000,
    StScan   = 9'b000100000,
    StDecide = 9'b001000000,
    StUpdate = 9'b010000000,
    StFinish = 9'b100000000
  } state_e;

endpackage

### design/pnfv_cell.sv
module pnfv_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             clear_i,
  input  logic             shift_i,
  input  pnfv_pkg::entry_t d_i,
  output pnfv_pkg::entry_t q_o
);
  import pnfv_pkg::*;

  logic               valid_q;
  logic [31:0]        ts_q;
  logic signed [11:0] level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (clear_i) begin
      valid_q <= 1'b0;
    end else if (shift_i) begin
      valid_q <= d_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      ts_q    <= d_i.ts;
      level_q <= d_i.level;
    end
  end

  assign q_o = '{valid: valid_q, ts: ts_q, level: level_q};

endmodule

### design/pnfv_cfg.sv
module pnfv_cfg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output pnfv_pkg::cfg_t cfg_o
);
  import pnfv_pkg::*;

  cfg_t cfg_q;
  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[4:2];
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.abs_thr    <= RstAbsThr;
      cfg_q.margin     <= RstMargin;
      cfg_q.silence    <= RstSilence;
      cfg_q.min_rec    <= RstMinRec;
      cfg_q.min_speech <= RstMinSpeech;
    end else if (wr) begin
      case (idx)
        RegAbsThr:    cfg_q.abs_thr    <= pwdata[11:0];
        RegMargin:    cfg_q.margin     <= pwdata[10:0];
        RegSilence:   cfg_q.silence    <= pwdata[15:0];
        RegMinRec:    cfg_q.min_rec    <= pwdata[15:0];
        RegMinSpeech: cfg_q.min_speech <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegAbsThr:    prdata = {{20{cfg_q.abs_thr[11]}}, cfg_q.abs_thr};
      RegMargin:    prdata = {21'd0, cfg_q.margin};
      RegSilence:   prdata = {16'd0, cfg_q.silence};
      RegMinRec:    prdata = {16'd0, cfg_q.min_rec};
      RegMinSpeech: prdata = {16'd0, cfg_q.min_speech};
      default:      prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

### design/percentile_noise_floor_vad.sv
// voice activity detector with a percentile noise floor
// input channel: in_valid_i / in_stall_o carry one transaction per frame, req_type_i = 1
// restarts detection. output channel: out_valid_o / out_stall_i, exactly one transaction
// per input transaction, in order. registers sit on a small apb-style port.
// the history lives in a ring of HISTORY_DEPTH cells that rotates one place per cycle
// in the insert, window, search and scan states; the controller looks at the last cell
// only. a frame before speech is found makes one rotation to age out old entries and
// count them, eleven rotations of a binary search for the 20th percentile and one
// rotation to scan for speech. a frame after speech skips the ring and only checks
// its level against the threshold; a restart goes straight to the result. one frame is
// worked on at a time; in_stall_o is high from the accepting edge until the result is
// registered, so the next transaction can be taken as soon as it is.
// a finished result waits in the output register while out_stall_i is high, and the
// next frame may already be accepted meanwhile; a second result holds the block busy
// until the first one is taken.
// reset and restart empty the history and clear the detector state; registers keep
// their values across a restart.
module percentile_noise_floor_vad #(
  parameter int unsigned HISTORY_DEPTH = pnfv_pkg::DefHistoryDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               req_type_i,
  input  logic [31:0]        frame_time_i,
  input  logic signed [15:0] frame_level_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               speech_found_now_o,
  output logic signed [11:0] noise_floor_o,
  output logic signed [11:0] effective_threshold_o,
  output logic               stop_now_o
);
  import pnfv_pkg::*;

  localparam int unsigned PosW = $clog2(HISTORY_DEPTH);
  localparam int unsigned CntW = $clog2(HISTORY_DEPTH + 1);

  cfg_t cfg;

  pnfv_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  state_e state_q, state_d;

  logic [31:0]        now_q, now_d, latest_q, latest_d, voice_q, voice_d;
  logic               vvalid_q, vvalid_d, speech_q, speech_d, found_now_q, found_now_d;
  logic signed [11:0] level_q, level_d, floor_q, floor_d, thr_q, thr_d;
  logic [PosW-1:0]    pos_q, pos_d;
  logic [CntW-1:0]    count_q, count_d, want_q, want_d, cnt_le_q, cnt_le_d;
  logic [2:0]         rem_q, rem_d;
  logic [3:0]         pass_q, pass_d;
  logic signed [11:0] lo_q, lo_d, hi_q, hi_d;
  logic [31:0]        run_q, run_d, prev_q, prev_d, lv_q, lv_d;
  logic               first_q, first_d, found_q, found_d;
  logic               out_valid_q, out_valid_d, o_found_q, o_found_d, o_stop_q, o_stop_d;
  logic signed [11:0] o_floor_q, o_floor_d, o_thr_q, o_thr_d;

  // ring of cells
  entry_t cell_q [HISTORY_DEPTH];
  entry_t head_d, tap;
  logic   shift, clear;

  assign tap = cell_q[HISTORY_DEPTH-1];

  for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      pnfv_cell u_cell (
        .clk_i (clk_i), .rst_ni (rst_ni), .clear_i (clear), .shift_i (shift),
        .d_i (head_d), .q_o (cell_q[i])
      );
    end else begin : g_body
      pnfv_cell u_cell (
        .clk_i (clk_i), .rst_ni (rst_ni), .clear_i (clear), .shift_i (shift),
        .d_i (cell_q[i-1]), .q_o (cell_q[i])
      );
    end
  end

  logic               accept, pos_end, drop, emit;
  logic [31:0]        now_in, age, diff, step, run_new, stop_age;
  logic signed [11:0] level_in;
  logic [17:0]        win_sum, window;
  logic [12:0]        mid_sum, cand;
  logic signed [11:0] mid;
  logic [32:0]        run_sum;
  logic [CntW-1:0]    cnt_le_next;
  logic               stop;

  assign in_stall_o = (state_q != StIdle);
  assign accept     = in_valid_i & ~in_stall_o;
  assign clear      = accept & req_type_i;
  assign shift      = (state_q == StInsert) | (state_q == StWindow) |
                      (state_q == StSearch) | (state_q == StScan);
  assign pos_end    = (pos_q == PosW'(HISTORY_DEPTH - 1));
  assign emit       = (state_q == StFinish) & (~out_valid_q | ~out_stall_i);

  assign now_in = (frame_time_i < latest_q) ? latest_q : frame_time_i;
  always_comb begin
    if (frame_level_i < 16'(LevelMin)) begin
      level_in = LevelMin;
    end else if (frame_level_i > 16'sd0) begin
      level_in = 12'sd0;
    end else begin
      level_in = frame_level_i[11:0];
    end
  end

  assign win_sum = {2'd0, cfg.silence} + {2'd0, cfg.min_speech} + WindowPadMs;
  assign window  = (win_sum < WindowMinMs) ? WindowMinMs : win_sum;
  assign age     = now_q - tap.ts;
  assign drop    = (state_q == StWindow) & tap.valid & (age > {14'd0, window});

  assign mid_sum = {lo_q[11], lo_q} + {hi_q[11], hi_q};
  assign mid     = mid_sum[12:1];
  assign cnt_le_next = cnt_le_q + CntW'(tap.valid && (tap.level <= mid));

  assign cand = {lo_q[11], lo_q} + {2'd0, cfg.margin};

  assign diff    = tap.ts - prev_q;
  assign step    = first_q ? 32'd0 : ((diff > StepCapMs) ? StepCapMs : diff);
  assign run_sum = {1'b0, run_q} + {1'b0, step};
  assign run_new = run_sum[32] ? 32'hFFFF_FFFF : run_sum[31:0];

  assign stop_age = now_q - voice_q;
  assign stop = speech_q && (now_q >= {16'd0, cfg.min_rec}) && vvalid_q &&
                (now_q >= voice_q) && (stop_age >= {16'd0, cfg.silence});

  always_comb begin
    head_d = tap;
    head_d.valid = tap.valid & ~drop;
    if (state_q == StInsert) begin
      head_d.valid = 1'b1;
      head_d.ts    = now_q;
      head_d.level = level_q;
    end
  end

  always_comb begin
    state_d     = state_q;
    now_d       = now_q;
    latest_d    = latest_q;
    voice_d     = voice_q;
    vvalid_d    = vvalid_q;
    speech_d    = speech_q;
    found_now_d = found_now_q;
    level_d     = level_q;
    floor_d     = floor_q;
    thr_d       = thr_q;
    pos_d       = shift ? (pos_end ? '0 : pos_q + 1'b1) : '0;
    count_d     = count_q;
    want_d      = want_q;
    cnt_le_d    = cnt_le_q;
    rem_d       = rem_q;
    pass_d      = pass_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    run_d       = run_q;
    prev_d      = prev_q;
    lv_d        = lv_q;
    first_d     = first_q;
    found_d     = found_q;
    out_valid_d = out_valid_q & out_stall_i;
    o_found_d   = o_found_q;
    o_stop_d    = o_stop_q;
    o_floor_d   = o_floor_q;
    o_thr_d     = o_thr_q;

    case (state_q)
      StIdle: begin
        if (accept) begin
          found_now_d = 1'b0;
          if (req_type_i) begin
            latest_d = 32'd0;
            voice_d  = 32'd0;
            vvalid_d = 1'b0;
            floor_d  = LevelMin;
            thr_d    = cfg.abs_thr;
            speech_d = 1'b0;
            state_d  = StFinish;
          end else begin
            now_d    = now_in;
            latest_d = now_in;
            level_d  = level_in;
            state_d  = speech_q ? StUpdate : StInsert;
          end
        end
      end
      StInsert: begin
        // the insert shift moves the ring by one place; full rotations follow
        pos_d   = '0;
        count_d = '0;
        want_d  = '0;
        rem_d   = '0;
        state_d = StWindow;
      end
      StWindow: begin
        if (tap.valid && !drop) begin
          count_d = count_q + 1'b1;
          if (count_q != '0) begin
            if (rem_q == PercentileDiv - 3'd1) begin
              rem_d  = '0;
              want_d = want_q + 1'b1;
            end else begin
              rem_d = rem_q + 3'd1;
            end
          end
        end
        if (pos_end) begin
          lo_d     = LevelMin;
          hi_d     = 12'sd0;
          pass_d   = '0;
          cnt_le_d = '0;
          state_d  = StSearch;
        end
      end
      StSearch: begin
        cnt_le_d = cnt_le_next;
        if (pos_end) begin
          cnt_le_d = '0;
          if (cnt_le_next > want_q) begin
            hi_d = mid;
          end else begin
            lo_d = mid + 12'sd1;
          end
          pass_d = pass_q + 4'd1;
          if (pass_q == SearchPasses - 4'd1) begin
            state_d = StThresh;
          end
        end
      end
      StThresh: begin
        floor_d = lo_q;
        thr_d   = ($signed(cand) > $signed({cfg.abs_thr[11], cfg.abs_thr})) ?
                  cand[11:0] : cfg.abs_thr;
        run_d   = '0;
        prev_d  = '0;
        lv_d    = '0;
        first_d = 1'b1;
        found_d = 1'b0;
        state_d = StScan;
      end
      StScan: begin
        if (tap.valid) begin
          prev_d  = tap.ts;
          first_d = 1'b0;
          if (tap.level >= thr_q) begin
            run_d = run_new;
            lv_d  = tap.ts;
            if (run_new >= {16'd0, cfg.min_speech}) begin
              found_d = 1'b1;
            end
          end else begin
            run_d = '0;
          end
        end
        if (pos_end) begin
          state_d = StDecide;
        end
      end
      StDecide: begin
        if (found_q) begin
          speech_d    = 1'b1;
          found_now_d = 1'b1;
          voice_d     = lv_q;
          vvalid_d    = 1'b1;
        end
        state_d = StFinish;
      end
      StUpdate: begin
        if (level_q >= thr_q) begin
          voice_d  = now_q;
          vvalid_d = 1'b1;
        end
        state_d = StFinish;
      end
      StFinish: begin
        if (emit) begin
          out_valid_d = 1'b1;
          o_found_d   = found_now_q;
          o_floor_d   = floor_q;
          o_thr_d     = thr_q;
          o_stop_d    = stop;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      now_q       <= '0;
      latest_q    <= '0;
      voice_q     <= '0;
      vvalid_q    <= 1'b0;
      speech_q    <= 1'b0;
      found_now_q <= 1'b0;
      level_q     <= '0;
      floor_q     <= LevelMin;
      thr_q       <= RstAbsThr;
      pos_q       <= '0;
      count_q     <= '0;
      want_q      <= '0;
      cnt_le_q    <= '0;
      rem_q       <= '0;
      pass_q      <= '0;
      lo_q        <= LevelMin;
      hi_q        <= '0;
      run_q       <= '0;
      prev_q      <= '0;
      lv_q        <= '0;
      first_q     <= 1'b1;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
      o_found_q   <= 1'b0;
      o_stop_q    <= 1'b0;
      o_floor_q   <= LevelMin;
      o_thr_q     <= RstAbsThr;
    end else begin
      state_q     <= state_d;
      now_q       <= now_d;
      latest_q    <= latest_d;
      voice_q     <= voice_d;
      vvalid_q    <= vvalid_d;
      speech_q    <= speech_d;
      found_now_q <= found_now_d;
      level_q     <= level_d;
      floor_q     <= floor_d;
      thr_q       <= thr_d;
      pos_q       <= pos_d;
      count_q     <= count_d;
      want_q      <= want_d;
      cnt_le_q    <= cnt_le_d;
      rem_q       <= rem_d;
      pass_q      <= pass_d;
      lo_q        <= lo_d;
      hi_q        <= hi_d;
      run_q       <= run_d;
      prev_q      <= prev_d;
      lv_q        <= lv_d;
      first_q     <= first_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
      o_found_q   <= o_found_d;
      o_stop_q    <= o_stop_d;
      o_floor_q   <= o_floor_d;
      o_thr_q     <= o_thr_d;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign speech_found_now_o    = o_found_q;
  assign noise_floor_o         = o_floor_q;
  assign effective_threshold_o = o_thr_q;
  assign stop_now_o            = o_stop_q;

endmodule
